// ===== src/bank_row_column_bump_allocator_unit_assert.svh =====
// Assertion macros for the bump allocator unit.
// Included by the top level; no other dependencies.
`ifndef BANK_ROW_COLUMN_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define BANK_ROW_COLUMN_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BRCBA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BRCBA_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRCBA_ASSERT(name, clk, rstn, prop, msg)
`define BRCBA_ASSERT_NR(name, clk, prop, msg)
`endif

`endif

// ===== src/brcba_pkg.sv =====
// Shared widths, codes and command type of the bump allocator unit.
// No dependencies.
package brcba_pkg;

  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned DIV_W     = SIZE_W + 1;
  localparam int unsigned CNT_W     = $clog2(DIV_W);
  localparam int unsigned BANK_W    = 4;
  localparam int unsigned SUB_W     = 6;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NB_W      = 5;
  localparam int unsigned NS_W      = 7;
  localparam int unsigned NR_W      = 11;
  localparam int unsigned NC_W      = 13;

  localparam logic [NB_W-1:0] BANK_MAX = NB_W'(16);
  localparam logic [NS_W-1:0] SUB_MAX  = NS_W'(64);
  localparam logic [NR_W-1:0] ROW_MAX  = NR_W'(1024);
  localparam logic [NC_W-1:0] COL_MAX  = NC_W'(4096);

  localparam logic [NB_W-1:0] BANK_RST = NB_W'(8);
  localparam logic [NS_W-1:0] SUB_RST  = NS_W'(16);
  localparam logic [NR_W-1:0] ROW_RST  = NR_W'(512);
  localparam logic [NC_W-1:0] COL_RST  = NC_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_COUNT = 3'd0,
    CFG_SUBARRAYS  = 3'd1,
    CFG_ROWS       = 3'd2,
    CFG_COLUMNS    = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_COLUMN   = 2'd0,
    LVL_ROW      = 2'd1,
    LVL_SUBARRAY = 2'd2,
    LVL_BANK     = 2'd3
  } level_e;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   commit;
    level_e level;
  } cmd_t;

endpackage

// ===== src/bank_row_column_bump_allocator_unit.sv =====
// Bump allocator over bank/subarray/row/column memory.
// The start coordinates are registered on acceptance and valid in the cycle after it.
// One allocation at a time: no new request is taken until the shared restoring divider
//   does four 33-step divisions (column, row, subarray, bank radix) with a commit each.
// Reset: pointer cleared to zero, geometry 8 banks, 16 subarrays, 512 rows, 2048 columns.
// Uses brcba_pkg, brcba_ctrl, brcba_datapath and the assertion header.
`include "bank_row_column_bump_allocator_unit_assert.svh"

module bank_row_column_bump_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [brcba_pkg::SIZE_W-1:0]    alloc_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [brcba_pkg::BANK_W-1:0]    start_bank_o,
  output logic [brcba_pkg::SUB_W-1:0]     start_subarray_o,
  output logic [brcba_pkg::ROW_W-1:0]     start_row_o,
  output logic [brcba_pkg::COL_W-1:0]     start_column_o,
  input  logic                            cfg_we_i,
  input  logic [brcba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brcba_pkg::CFG_W-1:0]     cfg_data_i
);

  brcba_pkg::cmd_t cmd;

  brcba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  brcba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .alloc_size_i     (alloc_size_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_bank_o     (start_bank_o),
    .start_subarray_o (start_subarray_o),
    .start_row_o      (start_row_o),
    .start_column_o   (start_column_o)
  );

  `BRCBA_ASSERT(a_accept_gives_result, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> out_valid_o, "accepted transaction produced no result")
  `BRCBA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "new transaction accepted while dividing")
  `BRCBA_ASSERT(a_cmd_exclusive, clk_i, rst_ni, $onehot0({cmd.load, cmd.step, cmd.commit}), "conflicting datapath commands")
  `BRCBA_ASSERT(a_commit_after_step, clk_i, rst_ni, cmd.commit |-> $past(cmd.step), "commit without a preceding divide step")

endmodule

// ===== src/brcba_datapath.sv =====
// Datapath of the bump allocator: geometry registers, free pointer,
// shared restoring divider and result registers. Uses brcba_pkg.
module brcba_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brcba_pkg::cmd_t                 cmd_i,
  input  logic [brcba_pkg::SIZE_W-1:0]    alloc_size_i,
  input  logic                            cfg_we_i,
  input  logic [brcba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brcba_pkg::CFG_W-1:0]     cfg_data_i,
  output logic [brcba_pkg::BANK_W-1:0]    start_bank_o,
  output logic [brcba_pkg::SUB_W-1:0]     start_subarray_o,
  output logic [brcba_pkg::ROW_W-1:0]     start_row_o,
  output logic [brcba_pkg::COL_W-1:0]     start_column_o
);

  logic [brcba_pkg::NB_W-1:0] bank_count_q;
  logic [brcba_pkg::NS_W-1:0] subarrays_q;
  logic [brcba_pkg::NR_W-1:0] rows_q;
  logic [brcba_pkg::NC_W-1:0] columns_q;

  logic [brcba_pkg::BANK_W-1:0] free_bank_q;
  logic [brcba_pkg::SUB_W-1:0]  free_sub_q;
  logic [brcba_pkg::ROW_W-1:0]  free_row_q;
  logic [brcba_pkg::COL_W-1:0]  free_col_q;

  logic [brcba_pkg::DIV_W-1:0] acc_q, acc_d;
  logic [brcba_pkg::COL_W-1:0] rem_q, rem_d;

  logic [brcba_pkg::NB_W-1:0] nb;
  logic [brcba_pkg::NS_W-1:0] ns;
  logic [brcba_pkg::NR_W-1:0] nr;
  logic [brcba_pkg::NC_W-1:0] nc;
  logic [brcba_pkg::NC_W-1:0] divisor;
  logic [brcba_pkg::NC_W-1:0] rs;
  logic [brcba_pkg::NC_W-1:0] rs_sub;
  logic                       qbit;
  logic [brcba_pkg::DIV_W-1:0] next_field;

  always_comb begin
    nb = (bank_count_q == '0) ? brcba_pkg::NB_W'(1) :
         (bank_count_q > brcba_pkg::BANK_MAX) ? brcba_pkg::BANK_MAX : bank_count_q;
    ns = (subarrays_q == '0) ? brcba_pkg::NS_W'(1) :
         (subarrays_q > brcba_pkg::SUB_MAX) ? brcba_pkg::SUB_MAX : subarrays_q;
    nr = (rows_q == '0) ? brcba_pkg::NR_W'(1) :
         (rows_q > brcba_pkg::ROW_MAX) ? brcba_pkg::ROW_MAX : rows_q;
    nc = (columns_q == '0) ? brcba_pkg::NC_W'(1) :
         (columns_q > brcba_pkg::COL_MAX) ? brcba_pkg::COL_MAX : columns_q;
  end

  always_comb begin
    case (cmd_i.level)
      brcba_pkg::LVL_COLUMN: begin
        divisor    = nc;
        next_field = brcba_pkg::DIV_W'(free_row_q);
      end
      brcba_pkg::LVL_ROW: begin
        divisor    = brcba_pkg::NC_W'(nr);
        next_field = brcba_pkg::DIV_W'(free_sub_q);
      end
      brcba_pkg::LVL_SUBARRAY: begin
        divisor    = brcba_pkg::NC_W'(ns);
        next_field = brcba_pkg::DIV_W'(free_bank_q);
      end
      brcba_pkg::LVL_BANK: begin
        divisor    = brcba_pkg::NC_W'(nb);
        next_field = '0;
      end
      default: begin
        divisor    = nc;
        next_field = '0;
      end
    endcase
  end

  assign rs     = {rem_q, acc_q[brcba_pkg::DIV_W-1]};
  assign qbit   = (rs >= divisor);
  assign rs_sub = rs - divisor;

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      acc_d = brcba_pkg::DIV_W'(alloc_size_i) + brcba_pkg::DIV_W'(free_col_q);
      rem_d = '0;
    end else if (cmd_i.step) begin
      acc_d = {acc_q[brcba_pkg::DIV_W-2:0], qbit};
      rem_d = qbit ? rs_sub[brcba_pkg::COL_W-1:0] : rs[brcba_pkg::COL_W-1:0];
    end else if (cmd_i.commit) begin
      acc_d = acc_q + next_field;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      start_bank_o     <= free_bank_q;
      start_subarray_o <= free_sub_q;
      start_row_o      <= free_row_q;
      start_column_o   <= free_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= brcba_pkg::BANK_RST;
      subarrays_q  <= brcba_pkg::SUB_RST;
      rows_q       <= brcba_pkg::ROW_RST;
      columns_q    <= brcba_pkg::COL_RST;
      free_bank_q  <= '0;
      free_sub_q   <= '0;
      free_row_q   <= '0;
      free_col_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brcba_pkg::CFG_BANK_COUNT: bank_count_q <= cfg_data_i[brcba_pkg::NB_W-1:0];
        brcba_pkg::CFG_SUBARRAYS:  subarrays_q  <= cfg_data_i[brcba_pkg::NS_W-1:0];
        brcba_pkg::CFG_ROWS:       rows_q       <= cfg_data_i[brcba_pkg::NR_W-1:0];
        brcba_pkg::CFG_COLUMNS:    columns_q    <= cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i inside {brcba_pkg::CFG_BANK_COUNT, brcba_pkg::CFG_SUBARRAYS,
                              brcba_pkg::CFG_ROWS, brcba_pkg::CFG_COLUMNS}) begin
        free_bank_q <= '0;
        free_sub_q  <= '0;
        free_row_q  <= '0;
        free_col_q  <= '0;
      end
    end else if (cmd_i.commit) begin
      case (cmd_i.level)
        brcba_pkg::LVL_COLUMN:   free_col_q  <= rem_q;
        brcba_pkg::LVL_ROW:      free_row_q  <= rem_q[brcba_pkg::ROW_W-1:0];
        brcba_pkg::LVL_SUBARRAY: free_sub_q  <= rem_q[brcba_pkg::SUB_W-1:0];
        brcba_pkg::LVL_BANK:     free_bank_q <= rem_q[brcba_pkg::BANK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/brcba_ctrl.sv =====
// Controller of the bump allocator: handshakes, divide step counter and
// coordinate sequencing. Uses brcba_pkg.
module brcba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output brcba_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e                     state_q;
  logic [brcba_pkg::CNT_W-1:0] cnt_q;
  brcba_pkg::level_e          level_q;
  logic                       out_valid_q;
  logic                       slot_free;
  logic                       accept;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign accept      = in_valid_i && (state_q == ST_IDLE) && slot_free;
  assign in_stall_o  = !((state_q == ST_IDLE) && slot_free);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = accept;
  assign cmd_o.step   = (state_q == ST_DIV);
  assign cmd_o.commit = (state_q == ST_COMMIT);
  assign cmd_o.level  = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      level_q     <= brcba_pkg::LVL_COLUMN;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
            level_q <= brcba_pkg::LVL_COLUMN;
          end
        end
        ST_DIV: begin
          if (cnt_q == brcba_pkg::CNT_W'(brcba_pkg::DIV_W - 1)) begin
            state_q <= ST_COMMIT;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ST_COMMIT: begin
          cnt_q <= '0;
          if (level_q == brcba_pkg::LVL_BANK) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_DIV;
            level_q <= brcba_pkg::level_e'(level_q + 2'd1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/bank_row_column_bump_allocator_unit_tb.sv =====
// Self-checking testbench for the bank/subarray/row/column bump allocator.
// Predicts each allocation start from its own pointer and geometry copy; uses brcba_pkg.
// Drives random valid/stall gaps, geometry rewrites and one long output hold-off.
module bank_row_column_bump_allocator_unit_tb;
  import brcba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ALLOCS  = 128;
  localparam int unsigned GAP_FREE_FROM = 10;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned STALL_LIMIT   = 8000;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [SUB_W-1:0]  subarray;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
  } alloc_start_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [SIZE_W-1:0]    alloc_size_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [BANK_W-1:0]    start_bank_o;
  logic [SUB_W-1:0]     start_subarray_o;
  logic [ROW_W-1:0]     start_row_o;
  logic [COL_W-1:0]     start_column_o;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i   = '0;

  bank_row_column_bump_allocator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .alloc_size_i     (alloc_size_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .start_bank_o     (start_bank_o),
    .start_subarray_o (start_subarray_o),
    .start_row_o      (start_row_o),
    .start_column_o   (start_column_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  logic [NB_W-1:0]   geo_banks     = BANK_RST;
  logic [NS_W-1:0]   geo_subarrays = SUB_RST;
  logic [NR_W-1:0]   geo_rows      = ROW_RST;
  logic [NC_W-1:0]   geo_columns   = COL_RST;
  logic [BANK_W-1:0] ptr_bank      = '0;
  logic [SUB_W-1:0]  ptr_subarray  = '0;
  logic [ROW_W-1:0]  ptr_row       = '0;
  logic [COL_W-1:0]  ptr_column    = '0;

  logic [SIZE_W-1:0] alloc_pending[$];
  alloc_start_t      starts_due[$];
  alloc_start_t      start_want;
  logic              in_fire_q    = 1'b0;
  bit                traffic_gaps = 1'b1;
  int unsigned       in_gap       = 0;
  int unsigned       out_gap      = 0;
  int unsigned       hold_asked   = 0;
  int unsigned       hold_served  = 0;
  int unsigned       hold_left    = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned eff_radix(input logic [NC_W-1:0] v,
                                                input logic [NC_W-1:0] hi);
    if (v == '0) return 64'(1);
    if (v > hi) return 64'(hi);
    return 64'(v);
  endfunction

  function automatic alloc_start_t bump_advance(input logic [SIZE_W-1:0] size);
    longint unsigned nb, ns, nr, nc, carry;
    alloc_start_t    start;
    nb = eff_radix(NC_W'(geo_banks), NC_W'(BANK_MAX));
    ns = eff_radix(NC_W'(geo_subarrays), NC_W'(SUB_MAX));
    nr = eff_radix(NC_W'(geo_rows), NC_W'(ROW_MAX));
    nc = eff_radix(geo_columns, COL_MAX);
    start = '{ptr_bank, ptr_subarray, ptr_row, ptr_column};
    carry = 64'(ptr_column) + 64'(size);
    ptr_column = COL_W'(carry % nc);
    carry = carry / nc + 64'(ptr_row);
    ptr_row = ROW_W'(carry % nr);
    carry = carry / nr + 64'(ptr_subarray);
    ptr_subarray = SUB_W'(carry % ns);
    carry = carry / ns + 64'(ptr_bank);
    ptr_bank = BANK_W'(carry % nb);
    return start;
  endfunction

  function automatic void apply_geometry_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_W-1:0] data);
    case (idx)
      CFG_BANK_COUNT: geo_banks = data[NB_W-1:0];
      CFG_SUBARRAYS:  geo_subarrays = data[NS_W-1:0];
      CFG_ROWS:       geo_rows = data[NR_W-1:0];
      CFG_COLUMNS:    geo_columns = data[NC_W-1:0];
      default:        return;
    endcase
    ptr_bank = '0;
    ptr_subarray = '0;
    ptr_row = '0;
    ptr_column = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && !in_stall_o;
      if (cfg_we_i) apply_geometry_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) starts_due.push_back(bump_advance(alloc_size_i));
      if (out_valid_o && !out_stall_i) begin
        if (starts_due.size() == 0) begin
          report_mismatch("allocation result with no transaction outstanding");
        end else begin
          start_want = starts_due.pop_front();
          if (start_bank_o !== start_want.bank)
            report_mismatch($sformatf("start_bank got %0d expected %0d",
                                      start_bank_o, start_want.bank));
          if (start_subarray_o !== start_want.subarray)
            report_mismatch($sformatf("start_subarray got %0d expected %0d",
                                      start_subarray_o, start_want.subarray));
          if (start_row_o !== start_want.row)
            report_mismatch($sformatf("start_row got %0d expected %0d",
                                      start_row_o, start_want.row));
          if (start_column_o !== start_want.column)
            report_mismatch($sformatf("start_column got %0d expected %0d",
                                      start_column_o, start_want.column));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT after %0d cycles without a transaction", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_fire_q) void'(alloc_pending.pop_front());
      if (in_valid_i && !in_fire_q) begin
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (alloc_pending.size() != 0 && traffic_gaps && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (alloc_pending.size() != 0) begin
        in_valid_i   <= 1'b1;
        alloc_size_i <= alloc_pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic drain_allocs();
    while (alloc_pending.size() != 0 || starts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_geometry(input logic [CFG_W-1:0] banks, input logic [CFG_W-1:0] subs,
                                    input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    write_geometry(CFG_BANK_COUNT, banks);
    write_geometry(CFG_SUBARRAYS, subs);
    write_geometry(CFG_ROWS, rows);
    write_geometry(CFG_COLUMNS, cols);
  endtask

  function automatic logic [CFG_W-1:0] pick_radix(input logic [CFG_W-1:0] hi,
                                                  input int unsigned width);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(hi + 1, (1 << width) - 1));
      2:       return hi;
      3:       return CFG_W'($urandom);
      4, 5:    return CFG_W'($urandom_range(1, 4));
      default: return CFG_W'($urandom_range(1, hi));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    longint unsigned nc, nr;
    nc = eff_radix(geo_columns, COL_MAX);
    nr = eff_radix(NC_W'(geo_rows), NC_W'(ROW_MAX));
    case ($urandom_range(0, 15))
      0:             return '0;
      1, 2, 3, 4, 5: return SIZE_W'($urandom_range(0, 32'(2 * nc)));
      6, 7, 8:       return SIZE_W'($urandom_range(0, 32'(2 * nc * nr)));
      9, 10, 11:     return $urandom;
      12:            return '1 - SIZE_W'($urandom_range(0, 32'(nc)));
      13:            return SIZE_W'(nc * $urandom_range(1, 4));
      default:       return SIZE_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    alloc_pending = '{32'd0, 32'd1, 32'd2046, 32'd1, 32'd0, 32'd8388607,
                      32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    drain_allocs();
    write_geometry(CFG_IDX_SPARE_LO, '1);
    write_geometry(CFG_IDX_SPARE_HI, '1);
    alloc_pending.push_back(32'd0);
    drain_allocs();
    write_all_geometry(CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
    alloc_pending = '{32'd5, 32'hFFFF_FFFF};
    drain_allocs();
    write_all_geometry(CFG_W'(BANK_MAX), CFG_W'(SUB_MAX), CFG_W'(ROW_MAX), COL_MAX);
    alloc_pending = '{32'hFFFF_FFFF, 32'd1, 32'd4096};
    drain_allocs();
    write_all_geometry('0, '0, '0, '0);
    alloc_pending = '{32'd3, 32'd77};
    drain_allocs();
    write_all_geometry(CFG_W'(31), CFG_W'(127), CFG_W'(2047), CFG_W'(8191));
    alloc_pending = '{32'd4095, 32'd1, 32'hFFFF_FFFF};
    drain_allocs();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      traffic_gaps = (phase < GAP_FREE_FROM) && (phase % 3 != 2);
      if ($urandom_range(0, 3) == 0)
        write_geometry(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                       CFG_W'($urandom));
      else
        write_all_geometry(pick_radix(CFG_W'(BANK_MAX), NB_W), pick_radix(CFG_W'(SUB_MAX), NS_W),
                           pick_radix(CFG_W'(ROW_MAX), NR_W), pick_radix(COL_MAX, NC_W));
      for (int unsigned n = 0; n < PHASE_ALLOCS; n++) alloc_pending.push_back(pick_size());
      if (phase == 1) hold_asked++;
      drain_allocs();
    end

    if (starts_due.size() != 0)
      report_mismatch($sformatf("%0d allocation results never arrived", starts_due.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
